>>> hw/rtl/taar_pkg.sv
package taar_pkg;

   localparam int NEIGHBORS_DEFAULT = 16;
   localparam int SLOTS_DEFAULT     = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 6;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef enum logic [1:0] {
      FUNC_INIT  = 2'd0,
      FUNC_ALLOC = 2'd1,
      FUNC_ROUTE = 2'd2,
      FUNC_WRITE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_DIRECT    = 2'd0,
      KIND_SUBTREE   = 2'd1,
      KIND_PARENT    = 2'd2,
      KIND_NOT_FOUND = 2'd3
   } route_kind_type;

   typedef enum logic [2:0] {
      CSR_MAX_CHILDREN = 3'd0,
      CSR_MAX_ROUTERS  = 3'd1,
      CSR_MAX_DEPTH    = 3'd2,
      CSR_OWN_DEPTH    = 3'd3,
      CSR_OWN_ADDRESS  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CSK_ADD,
      ST_CSK_MUL,
      ST_CSK_FIN,
      ST_ALLOC,
      ST_ALLOC_MUL,
      ST_ALLOC_FIN,
      ST_ROUTE_MUL,
      ST_ROUTE_CHK,
      ST_ROUTE_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        child;
      logic [15:0] addr;
   } nbr_entry_type;

endpackage

>>> hw/rtl/tree_address_alloc_router_core.sv
// One transaction at a time; allocate, route and init share the multiplier, and the neighbor
// scan reads one entry per cycle. A route to a destination outside the subtree skips the scan,
// an allocation with no free slot skips the multiply, and init skips its block-size loop when
// own_depth >= max_depth. A finished result waits in the output register while the next is taken.
// Reset (synchronous) clears the state, output valid, configuration registers, block size,
// slot maps and the neighbor valid and child bits.
module tree_address_alloc_router_core #(
   parameter int NEIGHBORS = taar_pkg::NEIGHBORS_DEFAULT,
   parameter int SLOTS     = taar_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_func,
   input  logic                            req_want_router,
   input  logic [15:0]                     req_dest_address,
   input  logic [3:0]                      req_entry_index,
   input  logic                            req_entry_valid,
   input  logic                            req_entry_is_child,
   input  logic [15:0]                     req_entry_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [15:0]                     rsp_given_address,
   output logic                            rsp_alloc_ok,
   output logic                            rsp_router_slot_free,
   output logic                            rsp_device_slot_free,
   output logic [1:0]                      rsp_route_kind,
   output logic [3:0]                      rsp_route_index,
   output logic [15:0]                     rsp_block_size,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [taar_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [taar_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [taar_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int NBR_W  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [5:0]  max_children_ff, max_children_in;
   logic [4:0]  max_routers_ff, max_routers_in;
   logic [3:0]  max_depth_ff, max_depth_in;
   logic [3:0]  own_depth_ff, own_depth_in;
   logic [15:0] own_address_ff, own_address_in;

   taar_pkg::state_type      state_ff, state_in;
   taar_pkg::func_type       func_ff, func_in;
   logic                     want_router_ff, want_router_in;
   logic [15:0]              dest_ff, dest_in;
   logic [15:0]              skip_ff, skip_in;
   logic [SLOTS-1:0]         router_map_ff, router_map_in;
   logic [SLOTS-1:0]         device_map_ff, device_map_in;
   logic [16:0]              sum_ff, sum_in;
   logic [16:0]              pow_ff, pow_in;
   logic [3:0]               iter_ff, iter_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [NBR_W:0]           rd_idx_ff, rd_idx_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [NBR_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     sub_hit_ff, sub_hit_in;
   logic [NBR_W-1:0]         sub_idx_ff, sub_idx_in;
   logic [15:0]              res_given_ff, res_given_in;
   logic                     res_ok_ff, res_ok_in;
   taar_pkg::route_kind_type res_kind_ff, res_kind_in;
   logic [3:0]               res_ridx_ff, res_ridx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_given_ff, rsp_given_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic                     rsp_rfree_ff, rsp_rfree_in;
   logic                     rsp_dfree_ff, rsp_dfree_in;
   taar_pkg::route_kind_type rsp_kind_ff, rsp_kind_in;
   logic [3:0]               rsp_ridx_ff, rsp_ridx_in;
   logic [15:0]              rsp_bsize_ff, rsp_bsize_in;

   logic [taar_pkg::MUL_A_W-1:0] mul_a;
   logic [taar_pkg::MUL_B_W-1:0] mul_b;
   logic [taar_pkg::MUL_P_W-1:0] prod;

   logic                    tbl_wr_en;
   logic [NBR_W-1:0]        tbl_wr_idx;
   taar_pkg::nbr_entry_type tbl_wr_entry;
   taar_pkg::nbr_entry_type rd_entry;

   logic [5:0]        router_cnt, device_cnt;
   logic [6:0]        dev_diff;
   logic [SLOTS-1:0]  router_mask, device_mask, avail;
   logic [SLOT_W-1:0] slot_first;
   logic              slot_found;
   logic              router_free, device_free;
   logic [3:0]        iter_last;
   logic [17:0]       sum_next;
   logic signed [24:0] upper;
   logic              in_subtree;
   logic              hit_direct, hit_sub;
   logic [6:0]        entry_idx_wide;
   logic              wr_in_range;
   logic              csr_write;

   taar_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   taar_nbr_table #(
      .NEIGHBORS (NEIGHBORS),
      .NBR_W     (NBR_W)
   ) u_nbr_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_idx   (tbl_wr_idx),
      .wr_entry (tbl_wr_entry),
      .rd_idx   (rd_idx_ff[NBR_W-1:0]),
      .rd_entry (rd_entry)
   );

   // slot counts and free flags
   always_comb begin
      router_cnt = ({1'b0, max_routers_ff} < 6'(SLOTS)) ? {1'b0, max_routers_ff} : 6'(SLOTS);
      dev_diff   = {1'b0, max_children_ff} - {2'b0, max_routers_ff};
      if (max_children_ff <= {1'b0, max_routers_ff}) begin
         device_cnt = 6'd0;
      end else if (dev_diff < 7'(SLOTS)) begin
         device_cnt = 6'(dev_diff);
      end else begin
         device_cnt = 6'(SLOTS);
      end
      for (int i = 0; i < SLOTS; i++) begin
         router_mask[i] = 6'(i) < router_cnt;
         device_mask[i] = 6'(i) < device_cnt;
      end
      router_free = |(~router_map_ff & router_mask);
      device_free = |(~device_map_ff & device_mask);
      avail = want_router_ff ? (~router_map_ff & router_mask) : (~device_map_ff & device_mask);
      slot_found = |avail;
      slot_first = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            slot_first = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      iter_last  = max_depth_ff - own_depth_ff - 4'd1;
      sum_next   = {1'b0, sum_ff} + {1'b0, pow_ff};
      upper      = $signed({9'd0, own_address_ff}) + $signed({2'd0, prod})
                 + $signed({19'd0, max_children_ff}) - $signed({20'd0, max_routers_ff});
      in_subtree = (dest_ff > own_address_ff) && ($signed({9'd0, dest_ff}) <= upper);
      hit_direct = rd_entry.valid && rd_entry.child && (rd_entry.addr == dest_ff);
      hit_sub    = rd_entry.valid && rd_entry.child && (rd_entry.addr < dest_ff)
                 && (({1'b0, rd_entry.addr} + {1'b0, skip_ff}) > {1'b0, dest_ff});
      entry_idx_wide = 7'(req_entry_index);
      wr_in_range    = entry_idx_wide < 7'(NEIGHBORS);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      want_router_in = want_router_ff;
      dest_in        = dest_ff;
      skip_in        = skip_ff;
      router_map_in  = router_map_ff;
      device_map_in  = device_map_ff;
      sum_in         = sum_ff;
      pow_in         = pow_ff;
      iter_in        = iter_ff;
      slot_in        = slot_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      sub_hit_in     = sub_hit_ff;
      sub_idx_in     = sub_idx_ff;
      res_given_in   = res_given_ff;
      res_ok_in      = res_ok_ff;
      res_kind_in    = res_kind_ff;
      res_ridx_in    = res_ridx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_given_in   = rsp_given_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_rfree_in   = rsp_rfree_ff;
      rsp_dfree_in   = rsp_dfree_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_ridx_in    = rsp_ridx_ff;
      rsp_bsize_in   = rsp_bsize_ff;
      mul_a          = pow_ff;
      mul_b          = {1'b0, max_routers_ff};
      tbl_wr_en      = 1'b0;
      tbl_wr_idx     = NBR_W'(req_entry_index);
      tbl_wr_entry   = '{valid: req_entry_valid, child: req_entry_is_child,
                         addr: req_entry_address};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         taar_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in        = taar_pkg::func_type'(req_func);
               want_router_in = req_want_router;
               dest_in        = req_dest_address;
               res_given_in   = 16'd0;
               res_ok_in      = 1'b0;
               res_kind_in    = taar_pkg::KIND_NOT_FOUND;
               res_ridx_in    = 4'd0;
               unique case (taar_pkg::func_type'(req_func))
                  taar_pkg::FUNC_INIT: begin
                     if (own_depth_ff >= max_depth_ff) begin
                        skip_in       = 16'd0;
                        router_map_in = '0;
                        device_map_in = '0;
                        state_in      = taar_pkg::ST_DONE;
                     end else begin
                        sum_in   = 17'd0;
                        pow_in   = 17'd1;
                        iter_in  = 4'd0;
                        state_in = taar_pkg::ST_CSK_ADD;
                     end
                  end
                  taar_pkg::FUNC_ALLOC: state_in = taar_pkg::ST_ALLOC;
                  taar_pkg::FUNC_ROUTE: state_in = taar_pkg::ST_ROUTE_MUL;
                  taar_pkg::FUNC_WRITE: begin
                     tbl_wr_en = wr_in_range;
                     state_in  = taar_pkg::ST_DONE;
                  end
                  default: state_in = taar_pkg::ST_DONE;
               endcase
            end
         end
         taar_pkg::ST_CSK_ADD: begin
            if (iter_ff < iter_last) begin
               sum_in   = (sum_next > 18'd65536) ? 17'h10000 : sum_next[16:0];
               mul_a    = pow_ff;
               mul_b    = {1'b0, max_routers_ff};
               state_in = taar_pkg::ST_CSK_MUL;
            end else begin
               mul_a    = sum_ff;
               mul_b    = max_children_ff;
               state_in = taar_pkg::ST_CSK_FIN;
            end
         end
         taar_pkg::ST_CSK_MUL: begin
            pow_in   = (prod > taar_pkg::MUL_P_W'(65536)) ? 17'h10000 : prod[16:0];
            iter_in  = iter_ff + 4'd1;
            state_in = taar_pkg::ST_CSK_ADD;
         end
         taar_pkg::ST_CSK_FIN: begin
            skip_in       = (prod >= taar_pkg::MUL_P_W'(65535)) ? 16'hFFFF
                          : prod[15:0] + 16'd1;
            router_map_in = '0;
            device_map_in = '0;
            state_in      = taar_pkg::ST_DONE;
         end
         taar_pkg::ST_ALLOC: begin
            if (slot_found) begin
               slot_in = slot_first;
               if (want_router_ff) begin
                  router_map_in[slot_first] = 1'b1;
               end else begin
                  device_map_in[slot_first] = 1'b1;
               end
               state_in = taar_pkg::ST_ALLOC_MUL;
            end else begin
               state_in = taar_pkg::ST_DONE;
            end
         end
         taar_pkg::ST_ALLOC_MUL: begin
            mul_a    = {1'b0, skip_ff};
            mul_b    = want_router_ff ? taar_pkg::MUL_B_W'(slot_ff) : {1'b0, max_routers_ff};
            state_in = taar_pkg::ST_ALLOC_FIN;
         end
         taar_pkg::ST_ALLOC_FIN: begin
            res_given_in = own_address_ff + prod[15:0] + 16'd1
                         + (want_router_ff ? 16'd0 : 16'(slot_ff));
            res_ok_in    = 1'b1;
            state_in     = taar_pkg::ST_DONE;
         end
         taar_pkg::ST_ROUTE_MUL: begin
            mul_a    = {1'b0, skip_ff};
            mul_b    = {1'b0, max_routers_ff};
            state_in = taar_pkg::ST_ROUTE_CHK;
         end
         taar_pkg::ST_ROUTE_CHK: begin
            if (in_subtree) begin
               rd_idx_in  = '0;
               sub_hit_in = 1'b0;
               state_in   = taar_pkg::ST_ROUTE_SCAN;
            end else begin
               res_kind_in = taar_pkg::KIND_PARENT;
               state_in    = taar_pkg::ST_DONE;
            end
         end
         taar_pkg::ST_ROUTE_SCAN: begin
            if (cmp_vld_ff && hit_direct) begin
               res_kind_in = taar_pkg::KIND_DIRECT;
               res_ridx_in = 4'(cmp_idx_ff);
               state_in    = taar_pkg::ST_DONE;
            end else begin
               if (cmp_vld_ff && hit_sub) begin
                  sub_hit_in = 1'b1;
                  sub_idx_in = cmp_idx_ff;
               end
               if (rd_idx_ff < (NBR_W + 1)'(NEIGHBORS)) begin
                  cmp_vld_in = 1'b1;
                  cmp_idx_in = rd_idx_ff[NBR_W-1:0];
                  rd_idx_in  = rd_idx_ff + 1'b1;
               end else if (cmp_vld_ff) begin
                  if (sub_hit_in) begin
                     res_kind_in = taar_pkg::KIND_SUBTREE;
                     res_ridx_in = 4'(sub_idx_in);
                  end else begin
                     res_kind_in = taar_pkg::KIND_NOT_FOUND;
                  end
                  state_in = taar_pkg::ST_DONE;
               end
            end
         end
         taar_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_given_in = res_given_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_rfree_in = router_free;
               rsp_dfree_in = device_free;
               rsp_kind_in  = res_kind_ff;
               rsp_ridx_in  = res_ridx_ff;
               rsp_bsize_in = skip_ff;
               state_in     = taar_pkg::ST_IDLE;
            end
         end
         default: state_in = taar_pkg::ST_IDLE;
      endcase
   end

   // configuration registers
   always_comb begin
      max_children_in = max_children_ff;
      max_routers_in  = max_routers_ff;
      max_depth_in    = max_depth_ff;
      own_depth_in    = own_depth_ff;
      own_address_in  = own_address_ff;
      csr_write       = csr_psel && csr_penable && csr_pwrite;
      csr_prdata      = '0;
      unique case (taar_pkg::csr_index_type'(csr_paddr[4:2]))
         taar_pkg::CSR_MAX_CHILDREN: begin
            csr_prdata = taar_pkg::CSR_DATA_W'(max_children_ff);
            if (csr_write) max_children_in = csr_pwdata[5:0];
         end
         taar_pkg::CSR_MAX_ROUTERS: begin
            csr_prdata = taar_pkg::CSR_DATA_W'(max_routers_ff);
            if (csr_write) max_routers_in = csr_pwdata[4:0];
         end
         taar_pkg::CSR_MAX_DEPTH: begin
            csr_prdata = taar_pkg::CSR_DATA_W'(max_depth_ff);
            if (csr_write) max_depth_in = csr_pwdata[3:0];
         end
         taar_pkg::CSR_OWN_DEPTH: begin
            csr_prdata = taar_pkg::CSR_DATA_W'(own_depth_ff);
            if (csr_write) own_depth_in = csr_pwdata[3:0];
         end
         taar_pkg::CSR_OWN_ADDRESS: begin
            csr_prdata = taar_pkg::CSR_DATA_W'(own_address_ff);
            if (csr_write) own_address_in = csr_pwdata[15:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= taar_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         skip_ff         <= 16'd0;
         router_map_ff   <= '0;
         device_map_ff   <= '0;
         cmp_vld_ff      <= 1'b0;
         max_children_ff <= 6'd0;
         max_routers_ff  <= 5'd0;
         max_depth_ff    <= 4'd0;
         own_depth_ff    <= 4'd0;
         own_address_ff  <= 16'd0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         skip_ff         <= skip_in;
         router_map_ff   <= router_map_in;
         device_map_ff   <= device_map_in;
         cmp_vld_ff      <= cmp_vld_in;
         max_children_ff <= max_children_in;
         max_routers_ff  <= max_routers_in;
         max_depth_ff    <= max_depth_in;
         own_depth_ff    <= own_depth_in;
         own_address_ff  <= own_address_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      want_router_ff <= want_router_in;
      dest_ff        <= dest_in;
      sum_ff         <= sum_in;
      pow_ff         <= pow_in;
      iter_ff        <= iter_in;
      slot_ff        <= slot_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      sub_hit_ff     <= sub_hit_in;
      sub_idx_ff     <= sub_idx_in;
      res_given_ff   <= res_given_in;
      res_ok_ff      <= res_ok_in;
      res_kind_ff    <= res_kind_in;
      res_ridx_ff    <= res_ridx_in;
      rsp_given_ff   <= rsp_given_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_rfree_ff   <= rsp_rfree_in;
      rsp_dfree_ff   <= rsp_dfree_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_ridx_ff    <= rsp_ridx_in;
      rsp_bsize_ff   <= rsp_bsize_in;
   end

   assign req_stall            = (state_ff != taar_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_given_address    = rsp_given_ff;
   assign rsp_alloc_ok         = rsp_ok_ff;
   assign rsp_router_slot_free = rsp_rfree_ff;
   assign rsp_device_slot_free = rsp_dfree_ff;
   assign rsp_route_kind       = rsp_kind_ff;
   assign rsp_route_index      = rsp_ridx_ff;
   assign rsp_block_size       = rsp_bsize_ff;
   assign csr_pready           = 1'b1;

   a_init_clears_maps: assert property (@(posedge clock) disable iff (reset)
      state_ff == taar_pkg::ST_CSK_FIN |=> router_map_ff == '0 && device_map_ff == '0)
      else $error("slot maps not cleared by init");

   a_alloc_no_route: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_kind_ff == taar_pkg::KIND_NOT_FOUND
                                    && rsp_ridx_ff == 4'd0)
      else $error("allocation result carries a route");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == taar_pkg::ST_ROUTE_SCAN |-> rd_idx_ff <= (NBR_W + 1)'(NEIGHBORS))
      else $error("neighbor scan past table end");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == taar_pkg::ST_DONE && !rsp_valid_ff
      |=> rsp_valid_ff && state_ff == taar_pkg::ST_IDLE)
      else $error("finished transaction not moved to output");

endmodule

>>> hw/rtl/taar_mul.sv
module taar_mul (
   input  logic                         clock,
   input  logic [taar_pkg::MUL_A_W-1:0] mul_a,
   input  logic [taar_pkg::MUL_B_W-1:0] mul_b,
   output logic [taar_pkg::MUL_P_W-1:0] prod
);

   logic [taar_pkg::MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= taar_pkg::MUL_P_W'(mul_a) * taar_pkg::MUL_P_W'(mul_b);
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/taar_nbr_table.sv
module taar_nbr_table #(
   parameter int NEIGHBORS = taar_pkg::NEIGHBORS_DEFAULT,
   parameter int NBR_W     = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [NBR_W-1:0]        wr_idx,
   input  taar_pkg::nbr_entry_type wr_entry,
   input  logic [NBR_W-1:0]        rd_idx,
   output taar_pkg::nbr_entry_type rd_entry
);

   logic [NEIGHBORS-1:0]    valid_ff;
   logic [NEIGHBORS-1:0]    child_ff;
   logic [15:0]             addr_ff [NEIGHBORS];
   taar_pkg::nbr_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         child_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_entry.valid;
         child_ff[wr_idx] <= wr_entry.child;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_ff[wr_idx] <= wr_entry.addr;
      end
      rd_entry_ff.valid <= valid_ff[rd_idx];
      rd_entry_ff.child <= child_ff[rd_idx];
      rd_entry_ff.addr  <= addr_ff[rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> bench/tree_address_alloc_router_core_tb.sv
`timescale 1ns / 1ps

module tree_address_alloc_router_core_tb;

   localparam int NBR         = taar_pkg::NEIGHBORS_DEFAULT;
   localparam int SLOT_COUNT  = taar_pkg::SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_OPS   = 102;

   typedef struct {
      taar_pkg::func_type func;
      logic               want_router;
      logic [15:0]        dest;
      logic [3:0]         idx;
      logic               ev;
      logic               ec;
      logic [15:0]        ea;
   } tree_req_type;

   typedef struct {
      logic [15:0]              given;
      logic                     ok;
      logic                     rfree;
      logic                     dfree;
      taar_pkg::route_kind_type kind;
      logic [3:0]               ridx;
      logic [15:0]              bsize;
   } tree_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = 2'd0;
   logic        req_want_router = 1'b0;
   logic [15:0] req_dest_address = 16'd0;
   logic [3:0]  req_entry_index = 4'd0;
   logic        req_entry_valid = 1'b0;
   logic        req_entry_is_child = 1'b0;
   logic [15:0] req_entry_address = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_given_address;
   logic        rsp_alloc_ok;
   logic        rsp_router_slot_free;
   logic        rsp_device_slot_free;
   logic [1:0]  rsp_route_kind;
   logic [3:0]  rsp_route_index;
   logic [15:0] rsp_block_size;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [taar_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [taar_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [taar_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   tree_address_alloc_router_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_want_router(req_want_router),
      .req_dest_address(req_dest_address),
      .req_entry_index(req_entry_index),
      .req_entry_valid(req_entry_valid),
      .req_entry_is_child(req_entry_is_child),
      .req_entry_address(req_entry_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_given_address(rsp_given_address),
      .rsp_alloc_ok(rsp_alloc_ok),
      .rsp_router_slot_free(rsp_router_slot_free),
      .rsp_device_slot_free(rsp_device_slot_free),
      .rsp_route_kind(rsp_route_kind),
      .rsp_route_index(rsp_route_index),
      .rsp_block_size(rsp_block_size),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   int cfg_children;
   int cfg_routers;
   int cfg_depth_max;
   int cfg_depth_own;
   int cfg_address;

   logic [15:0] block_len;
   logic [15:0] router_used;
   logic [15:0] device_used;
   logic        nbr_ok [NBR];
   logic        nbr_kid [NBR];
   logic [15:0] nbr_at [NBR];

   tree_req_type pending_ops[$];
   tree_rsp_type due_results[$];
   tree_req_type nxt;
   tree_req_type seen;
   tree_rsp_type want;

   bit req_fire;
   bit rsp_fire;
   bit send_calm;
   bit hold_calm;
   int send_gap;
   int hold_left;
   int errors;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] skip_of(int cm, int rm, int lm, int d);
      longint s;
      longint p;
      longint v;
      int k;
      if (d >= lm) return 16'd0;
      s = 0;
      p = 1;
      for (k = 0; k < lm - d - 1; k++) begin
         s += p;
         if (s > 65536) s = 65536;
         p *= rm;
         if (p > 65536) p = 65536;
      end
      v = 1 + longint'(cm) * s;
      return (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic int router_slots();
      return (cfg_routers < SLOT_COUNT) ? cfg_routers : SLOT_COUNT;
   endfunction

   function automatic int device_slots();
      if (cfg_children <= cfg_routers) return 0;
      return (cfg_children - cfg_routers < SLOT_COUNT) ? cfg_children - cfg_routers : SLOT_COUNT;
   endfunction

   function automatic int first_free(logic [15:0] map, int count);
      int i;
      for (i = 0; i < count; i++)
         if (!map[i]) return i;
      return -1;
   endfunction

   function automatic tree_rsp_type compute_response(tree_req_type q);
      tree_rsp_type o;
      int i;
      int direct;
      int sub;
      longint own;
      longint dst;
      longint upper;
      longint a;
      o.given = 16'd0;
      o.ok = 1'b0;
      o.kind = taar_pkg::KIND_NOT_FOUND;
      o.ridx = 4'd0;
      case (q.func)
         taar_pkg::FUNC_INIT: begin
            block_len = skip_of(cfg_children, cfg_routers, cfg_depth_max, cfg_depth_own);
            router_used = 16'd0;
            device_used = 16'd0;
         end
         taar_pkg::FUNC_ALLOC: begin
            if (q.want_router) begin
               i = first_free(router_used, router_slots());
               if (i >= 0) begin
                  router_used[i] = 1'b1;
                  o.given = 16'(longint'(cfg_address) + 1 + longint'(i) * block_len);
                  o.ok = 1'b1;
               end
            end else begin
               i = first_free(device_used, device_slots());
               if (i >= 0) begin
                  device_used[i] = 1'b1;
                  o.given = 16'(longint'(cfg_address) + longint'(cfg_routers) * block_len
                                + i + 1);
                  o.ok = 1'b1;
               end
            end
         end
         taar_pkg::FUNC_ROUTE: begin
            own = cfg_address;
            dst = q.dest;
            upper = own + longint'(cfg_routers) * block_len + cfg_children - cfg_routers;
            if (dst > own && dst <= upper) begin
               direct = -1;
               sub = -1;
               for (i = 0; i < NBR && direct < 0; i++) begin
                  if (nbr_ok[i] && nbr_kid[i]) begin
                     a = nbr_at[i];
                     if (a == dst) direct = i;
                     else if (a < dst && dst < a + block_len) sub = i;
                  end
               end
               if (direct >= 0) begin
                  o.kind = taar_pkg::KIND_DIRECT;
                  o.ridx = 4'(direct);
               end else if (sub >= 0) begin
                  o.kind = taar_pkg::KIND_SUBTREE;
                  o.ridx = 4'(sub);
               end
            end else begin
               o.kind = taar_pkg::KIND_PARENT;
            end
         end
         taar_pkg::FUNC_WRITE: begin
            nbr_ok[q.idx] = q.ev;
            nbr_kid[q.idx] = q.ec;
            nbr_at[q.idx] = q.ea;
         end
      endcase
      o.rfree = first_free(router_used, router_slots()) >= 0;
      o.dfree = first_free(device_used, device_slots()) >= 0;
      o.bsize = block_len;
      return o;
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         errors++;
      end
   endfunction

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic tree_req_type noise_req();
      tree_req_type q;
      q.func = taar_pkg::func_type'($urandom_range(0, 3));
      q.want_router = $urandom_range(0, 1);
      q.dest = $urandom_range(0, 65535);
      q.idx = $urandom_range(0, 15);
      q.ev = $urandom_range(0, 1);
      q.ec = $urandom_range(0, 1);
      q.ea = $urandom_range(0, 65535);
      return q;
   endfunction

   function automatic tree_req_type op_init();
      tree_req_type q;
      q = noise_req();
      q.func = taar_pkg::FUNC_INIT;
      return q;
   endfunction

   function automatic tree_req_type op_alloc(logic w);
      tree_req_type q;
      q = noise_req();
      q.func = taar_pkg::FUNC_ALLOC;
      q.want_router = w;
      return q;
   endfunction

   function automatic tree_req_type op_route(logic [15:0] d);
      tree_req_type q;
      q = noise_req();
      q.func = taar_pkg::FUNC_ROUTE;
      q.dest = d;
      return q;
   endfunction

   function automatic tree_req_type op_write(logic [3:0] i, logic v, logic c, logic [15:0] a);
      tree_req_type q;
      q = noise_req();
      q.func = taar_pkg::FUNC_WRITE;
      q.idx = i;
      q.ev = v;
      q.ec = c;
      q.ea = a;
      return q;
   endfunction

   function automatic logic [15:0] child_addr(logic [15:0] blk);
      logic [15:0] r;
      case ($urandom_range(0, 3))
         0: r = 16'(cfg_address + 1
                    + $urandom_range(0, cfg_routers > 0 ? cfg_routers - 1 : 0) * blk);
         1: r = 16'(cfg_address + 1 + $urandom_range(0, 15) * blk);
         2: r = 16'(cfg_address + cfg_routers * blk + $urandom_range(1, 16));
         default: r = 16'($urandom);
      endcase
      return r;
   endfunction

   function automatic logic [15:0] route_dest(logic [15:0] blk);
      longint span;
      logic [15:0] r;
      span = longint'(cfg_routers) * blk + cfg_children - cfg_routers;
      if (span > 65536) span = 65536;
      case ($urandom_range(0, 7))
         0: r = child_addr(blk);
         1, 2: r = 16'(child_addr(blk) + $urandom_range(1, blk > 1 ? blk - 1 : 1));
         3: r = (span > 0) ? 16'(cfg_address + $urandom_range(1, int'(span)))
                           : 16'(cfg_address + 1);
         4: r = 16'(cfg_address);
         5: r = 16'(longint'(cfg_address) + span + 1);
         6: r = 16'($urandom);
         default: r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
      return r;
   endfunction

   task automatic csr_write(taar_pkg::csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         taar_pkg::CSR_MAX_CHILDREN: cfg_children = val & 'h3F;
         taar_pkg::CSR_MAX_ROUTERS:  cfg_routers = val & 'h1F;
         taar_pkg::CSR_MAX_DEPTH:    cfg_depth_max = val & 'hF;
         taar_pkg::CSR_OWN_DEPTH:    cfg_depth_own = val & 'hF;
         taar_pkg::CSR_OWN_ADDRESS:  cfg_address = val & 'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_config(int cm, int rm, int lm, int d, int own);
      csr_write(taar_pkg::CSR_MAX_CHILDREN, cm);
      csr_write(taar_pkg::CSR_MAX_ROUTERS, rm);
      csr_write(taar_pkg::CSR_MAX_DEPTH, lm);
      csr_write(taar_pkg::CSR_OWN_DEPTH, d);
      csr_write(taar_pkg::CSR_OWN_ADDRESS, own);
   endtask

   task automatic settle();
      @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_mixed_ops(int count);
      logic [15:0] blk;
      int k;
      int r;
      blk = skip_of(cfg_children, cfg_routers, cfg_depth_max, cfg_depth_own);
      pending_ops.push_back(op_init());
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 18)
            pending_ops.push_back(op_write($urandom_range(0, 15), $urandom_range(0, 4) != 0,
                                           $urandom_range(0, 4) != 0, child_addr(blk)));
         else if (r < 42)
            pending_ops.push_back(op_alloc($urandom_range(0, 1)));
         else if (r < 85)
            pending_ops.push_back(op_route(route_dest(blk)));
         else if (r < 90)
            pending_ops.push_back(op_init());
         else
            pending_ops.push_back(noise_req());
      end
   endtask

   task automatic run_phase(int cm, int rm, int lm, int d, int own);
      set_config(cm, rm, lm, d, own);
      queue_mixed_ops(PHASE_OPS);
      settle();
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               nxt = pending_ops.pop_front();
               req_func <= nxt.func;
               req_want_router <= nxt.want_router;
               req_dest_address <= nxt.dest;
               req_entry_index <= nxt.idx;
               req_entry_valid <= nxt.ev;
               req_entry_is_child <= nxt.ec;
               req_entry_address <= nxt.ea;
               req_valid <= 1'b1;
               send_gap = draw_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) hold_left = draw_wait(hold_calm);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            seen.func = taar_pkg::func_type'(req_func);
            seen.want_router = req_want_router;
            seen.dest = req_dest_address;
            seen.idx = req_entry_index;
            seen.ev = req_entry_valid;
            seen.ec = req_entry_is_child;
            seen.ea = req_entry_address;
            due_results.push_back(compute_response(seen));
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result transaction with nothing expected");
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("given_address", want.given, rsp_given_address);
               check_field("alloc_ok", want.ok, rsp_alloc_ok);
               check_field("router_slot_free", want.rfree, rsp_router_slot_free);
               check_field("device_slot_free", want.dfree, rsp_device_slot_free);
               check_field("route_kind", 16'(want.kind), rsp_route_kind);
               check_field("route_index", want.ridx, rsp_route_index);
               check_field("block_size", want.bsize, rsp_block_size);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tree_address_alloc_router_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int k;
      cfg_children = 0;
      cfg_routers = 0;
      cfg_depth_max = 0;
      cfg_depth_own = 0;
      cfg_address = 0;
      block_len = 16'd0;
      router_used = 16'd0;
      device_used = 16'd0;
      for (k = 0; k < NBR; k++) begin
         nbr_ok[k] = 1'b0;
         nbr_kid[k] = 1'b0;
         nbr_at[k] = 16'd0;
      end
      errors = 0;
      cycle_count = 0;
      send_gap = 0;
      hold_left = 0;
      send_calm = 1'b0;
      hold_calm = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // skip 5, two router and two device slots, router addresses wrap past FFFF
      set_config(4, 2, 3, 1, 16'hFFFA);
      pending_ops.push_back(op_route(16'h0000));
      pending_ops.push_back(op_alloc(1'b1));
      pending_ops.push_back(op_init());
      repeat (3) pending_ops.push_back(op_alloc(1'b1));
      repeat (3) pending_ops.push_back(op_alloc(1'b0));
      pending_ops.push_back(op_write(4'd0, 1'b1, 1'b1, 16'hFFFB));
      pending_ops.push_back(op_write(4'd15, 1'b1, 1'b1, 16'hFFFF));
      pending_ops.push_back(op_write(4'd1, 1'b1, 1'b0, 16'hFFFD));
      pending_ops.push_back(op_route(16'hFFFB));
      pending_ops.push_back(op_route(16'hFFFC));
      pending_ops.push_back(op_route(16'hFFFF));
      pending_ops.push_back(op_route(16'hFFFD));
      pending_ops.push_back(op_route(16'hFFFA));
      pending_ops.push_back(op_write(4'd0, 1'b0, 1'b0, 16'h0000));
      pending_ops.push_back(op_route(16'hFFFC));
      pending_ops.push_back(op_init());
      pending_ops.push_back(op_alloc(1'b1));
      pending_ops.push_back(op_alloc(1'b0));
      settle();
      queue_mixed_ops(PHASE_OPS);
      settle();

      run_phase(32, 16, 15, 0, 16'h0000);
      run_phase(0, 0, 0, 0, 16'h0000);
      run_phase(6, 0, 4, 1, 16'h1000);
      run_phase(5, 1, 6, 2, 16'h2345);
      run_phase(3, 5, 5, 0, 16'h8000);
      run_phase(20, 4, 5, 3, 16'hFFFF);
      run_phase(32, 16, 2, 0, 16'hFF00);
      run_phase(32, 16, 15, 15, 16'hABCD);
      run_phase(12, 3, 4, 9, 16'h0042);
      for (k = 0; k < 2; k++) begin
         run_phase($urandom_range(0, 32), $urandom_range(0, 16), $urandom_range(1, 15), 0,
                   $urandom_range(0, 65535));
      end

      settle();
      repeat (NBR + 10) @(posedge clock);
      if (errors == 0) begin
         $display("tree_address_alloc_router_core_tb: done, clean");
      end else begin
         $display("tree_address_alloc_router_core_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/taar_pkg.sv
hw/rtl/taar_mul.sv
hw/rtl/taar_nbr_table.sv
hw/rtl/tree_address_alloc_router_core.sv
bench/tree_address_alloc_router_core_tb.sv
